/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/core/olad_pkg.sv */
package olad_pkg;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned ENTRIES_W   = 6;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DUMP   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] read_value;
    logic                      last_of_run;
    status_e                   status;
    logic [ENTRIES_W-1:0]      entries_held;
  } result_t;

endpackage

/* rtl/core/olad_if.sv */
interface olad_req_if;
  import olad_pkg::*;

  logic                      valid;
  logic                      ready;
  action_e                   action;
  logic signed [FIELD_W-1:0] operand_value;

  modport source (output valid, action, operand_value, input ready);
  modport sink (input valid, action, operand_value, output ready);
endinterface

interface olad_rsp_if;
  import olad_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] read_value;
  logic                      last_of_run;
  status_e                   status;
  logic [ENTRIES_W-1:0]      entries_held;

  modport source (output valid, read_value, last_of_run, status, entries_held, input ready);
  modport sink (input valid, read_value, last_of_run, status, entries_held, output ready);
endinterface

/* rtl/core/olad_out_stage.sv */
module olad_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  olad_pkg::result_t push_res_i,
  output logic              push_ready_o,
  olad_rsp_if.source        rsp_o
);
  import olad_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // The register takes a new item in the same cycle that the old one leaves.
  assign push_ready_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_valid_i && push_ready_o) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      res_q <= push_res_i;
    end
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.read_value   = res_q.read_value;
  assign rsp_o.last_of_run  = res_q.last_of_run;
  assign rsp_o.status       = res_q.status;
  assign rsp_o.entries_held = res_q.entries_held;

endmodule

/* rtl/core/ordered_list_append_delete.sv */
// Ordered list of up to DEPTH signed values with append, delete, dump and clear.
// req_i carries one action and an operand per item; rsp_o returns the results,
// each with a status and the entry count after the action.
// Append, clear, a dump of an empty list and a delete on an empty list give
// their single result in the next cycle, so such items can follow each other
// every cycle while rsp_o.ready stays high.
// A delete streams through the list memory once, reading one entry a cycle
// and writing each entry after the match one place down, then gives its
// single result; no new item is taken before that result is pushed.
// A dump reads one entry a cycle into the output register while the receiver
// keeps rsp_o.ready high, and last_of_run marks the tail entry.
// When the receiver stalls, the output register holds its item and a dump's memory
// read stream pauses with it; no result is dropped or repeated.
// Reset empties the list at once; the memory contents are not cleared since
// only entries below the count are ever read.
`include "assert_macros.svh"

module ordered_list_append_delete (
  input  logic      clk_i,
  input  logic      rst_ni,
  olad_req_if.sink  req_i,
  olad_rsp_if.source rsp_o
);
  import olad_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0] pend_idx_q, pend_idx_d;
  logic             pend_q, pend_d;
  logic             found_q, found_d;
  status_e          st_q, st_d;
  value_t           opv_q, opv_d;

  value_t           mem [DEPTH];
  value_t           rdata_q;
  logic             mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  value_t           mem_wdata;

  logic             push_valid, push_ready;
  result_t          push_res;
  logic             req_fire, issue, push_fire, hit;
  logic [ADDR_W-1:0] last_idx;
  value_t           opv_in;

  assign req_fire = req_i.valid && req_i.ready;
  // The operand is sign-extended or cut to the stored value width.
  assign opv_in   = value_t'(req_i.operand_value);
  assign last_idx = ADDR_W'(cnt_q - CNT_W'(1));
  assign hit      = (rdata_q == opv_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    pend_idx_d  = pend_idx_q;
    pend_d      = pend_q;
    found_d     = found_q;
    st_d        = st_q;
    opv_d       = opv_q;
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = opv_in;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_q[ADDR_W-1:0];
    push_valid  = 1'b0;
    push_res.read_value  = '0;
    push_res.last_of_run = 1'b1;
    push_res.status      = ST_OK;
    issue       = 1'b0;
    push_fire   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_i.ready = push_ready;
        if (req_fire) begin
          case (req_i.action)
            ACT_APPEND: begin
              push_valid = 1'b1;
              if (cnt_q < CNT_W'(DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[ADDR_W-1:0];
                cnt_d     = cnt_q + CNT_W'(1);
              end else begin
                push_res.status = ST_FULL;
              end
            end
            ACT_DELETE: begin
              if (cnt_q == '0) begin
                push_valid      = 1'b1;
                push_res.status = ST_NOTFOUND;
              end else begin
                state_d  = S_DEL;
                opv_d    = opv_in;
                rd_idx_d = '0;
                pend_d   = 1'b0;
                found_d  = 1'b0;
              end
            end
            ACT_DUMP: begin
              if (cnt_q == '0) begin
                push_valid      = 1'b1;
                push_res.status = ST_EMPTY;
              end else begin
                state_d  = S_DUMP;
                rd_idx_d = '0;
                pend_d   = 1'b0;
              end
            end
            default: begin
              push_valid = 1'b1;
              cnt_d      = '0;
            end
          endcase
        end
      end

      S_DEL: begin
        issue      = rd_idx_q < cnt_q;
        mem_re     = issue;
        pend_d     = issue;
        pend_idx_d = rd_idx_q[ADDR_W-1:0];
        if (issue) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (pend_q) begin
          // Past the match every entry moves one place toward the head.
          if (found_q) begin
            mem_we    = 1'b1;
            mem_waddr = pend_idx_q - ADDR_W'(1);
            mem_wdata = rdata_q;
          end else if (hit) begin
            found_d = 1'b1;
          end
          if (pend_idx_q == last_idx) begin
            state_d = S_EMIT;
            if (found_q || hit) begin
              cnt_d = cnt_q - CNT_W'(1);
              st_d  = ST_OK;
            end else begin
              st_d = ST_NOTFOUND;
            end
          end
        end
      end

      S_DUMP: begin
        push_valid           = pend_q;
        push_res.read_value  = FIELD_W'(rdata_q);
        push_res.last_of_run = (pend_idx_q == last_idx);
        push_fire            = pend_q && push_ready;
        // The read data register holds until its item has been pushed.
        issue                = (rd_idx_q < cnt_q) && (!pend_q || push_fire);
        mem_re               = issue;
        if (issue) begin
          rd_idx_d   = rd_idx_q + CNT_W'(1);
          pend_idx_d = rd_idx_q[ADDR_W-1:0];
          pend_d     = 1'b1;
        end else if (push_fire) begin
          pend_d = 1'b0;
        end
        if (push_fire && push_res.last_of_run) begin
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        push_valid      = 1'b1;
        push_res.status = st_q;
        if (push_ready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    push_res.entries_held = ENTRIES_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    st_q       <= st_d;
    opv_q      <= opv_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  olad_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_res_i   (push_res),
    .push_ready_o (push_ready),
    .rsp_o        (rsp_o)
  );

  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CNT_W'(DEPTH), "entry count above depth")
  `ASSERT_CLK(a_append_grows, clk_i, rst_ni, (req_fire && req_i.action == ACT_APPEND && cnt_q < CNT_W'(DEPTH)) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "append did not grow the list")
  `ASSERT_NEVER(a_port_clash, clk_i, rst_ni, mem_we && mem_re && (mem_waddr == mem_raddr), "read and write hit the same entry")
  `ASSERT_CLK(a_pend_in_list, clk_i, rst_ni, ((state_q == S_DUMP || state_q == S_DEL) && pend_q) |-> (CNT_W'(pend_idx_q) < cnt_q), "pending read outside the list")

endmodule

/* bench/tb_top.sv */
module tb_top;
  import olad_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_REQUESTS = 190;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 3 * DEPTH;
  localparam int MAX_REPORTS = 10;
  localparam int RECENT_KEEP = 16;

  typedef struct {
    action_e                   action;
    logic signed [FIELD_W-1:0] operand;
  } request_t;

  logic clk = 1'b0;
  logic rst_n;

  olad_req_if req_if ();
  olad_rsp_if rsp_if ();

  ordered_list_append_delete u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_t                  pending_requests[$];
  result_t                   expected_results[$];
  logic signed [FIELD_W-1:0] recent_values[$];

  // Shadow of the list as the block should hold it.
  value_t list_entries[DEPTH];
  int     list_len = 0;

  int total_requests = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int ready_left = 0;

  int action_counts[4] = '{default: 0};
  int full_refusals = 0;
  int missed_deletes = 0;
  int empty_dumps = 0;
  int longest_list = 0;

  task automatic predict_list_action(action_e act, logic signed [FIELD_W-1:0] operand);
    value_t  key;
    int      hit;
    result_t res;
    key = operand;
    hit = -1;
    res.read_value = '0;
    res.last_of_run = 1'b1;
    res.status = ST_OK;
    action_counts[act]++;
    case (act)
      ACT_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
          full_refusals++;
        end else begin
          list_entries[list_len] = key;
          list_len++;
        end
      end
      ACT_DELETE: begin
        for (int i = 0; i < list_len; i++) begin
          if (hit < 0 && list_entries[i] == key) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
          missed_deletes++;
        end else begin
          for (int j = hit; j + 1 < list_len; j++) list_entries[j] = list_entries[j + 1];
          list_len--;
        end
      end
      ACT_DUMP: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
          empty_dumps++;
        end
      end
      default: list_len = 0;
    endcase
    res.entries_held = ENTRIES_W'(list_len);
    if (list_len > longest_list) longest_list = list_len;
    if (act == ACT_DUMP && list_len > 0) begin
      for (int i = 0; i < list_len; i++) begin
        res.read_value = FIELD_W'(list_entries[i]);
        res.last_of_run = (i + 1 == list_len);
        expected_results.push_back(res);
      end
    end else begin
      expected_results.push_back(res);
    end
  endtask

  task automatic add_request(action_e act, logic signed [FIELD_W-1:0] operand);
    request_t req;
    req.action = act;
    req.operand = operand;
    pending_requests.push_back(req);
    if (act == ACT_APPEND) begin
      recent_values.push_back(operand);
      if (recent_values.size() > RECENT_KEEP) void'(recent_values.pop_front());
    end
  endtask

  // Small values repeat often, so deletes find matches and duplicates occur.
  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 6)) - 3;
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_delete_value();
    if (recent_values.size() > 0 && $urandom_range(0, 9) < 6)
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    return pick_value();
  endfunction

  task automatic add_fill_episode();
    add_request(ACT_CLEAR, $urandom());
    repeat ($urandom_range(33, 37)) add_request(ACT_APPEND, pick_value());
    add_request(ACT_DUMP, $urandom());
    repeat ($urandom_range(1, 4)) add_request(ACT_DELETE, pick_delete_value());
    repeat ($urandom_range(0, 3)) add_request(ACT_APPEND, pick_value());
    add_request(ACT_DUMP, $urandom());
  endtask

  task automatic add_mixed_episode();
    int pick;
    repeat ($urandom_range(6, 20)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) add_request(ACT_APPEND, pick_value());
      else if (pick < 75) add_request(ACT_DELETE, pick_delete_value());
      else if (pick < 92) add_request(ACT_DUMP, $urandom());
      else add_request(ACT_CLEAR, $urandom());
    end
  endtask

  always @(posedge clk) begin : drive_requests
    request_t upcoming;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_list_action(req_if.action, req_if.operand_value);
        requests_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          req_if.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          upcoming = pending_requests.pop_front();
          req_if.valid <= 1'b1;
          req_if.action <= upcoming.action;
          req_if.operand_value <= upcoming.operand;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : stall_results
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          rsp_if.ready <= 1'b0;
          ready_left = $urandom_range(0, 2);
        end
        1: begin
          rsp_if.ready <= 1'b0;
          ready_left = $urandom_range(9, 23);
        end
        2, 3: begin
          rsp_if.ready <= 1'b1;
          ready_left = $urandom_range(0, 3);
        end
        default: begin
          rsp_if.ready <= 1'b1;
          ready_left = $urandom_range(19, 79);
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: value %0d last %0b status %s entries %0d",
                   rsp_if.read_value, rsp_if.last_of_run, rsp_if.status.name(),
                   rsp_if.entries_held);
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.read_value !== want.read_value || rsp_if.last_of_run !== want.last_of_run ||
            rsp_if.status !== want.status || rsp_if.entries_held !== want.entries_held) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"Mismatch on result %0d: expected value %0d last %0b status %s ",
                      "entries %0d, got value %0d last %0b status %s entries %0d"},
                     results_seen, want.read_value, want.last_of_run, want.status.name(),
                     want.entries_held, rsp_if.read_value, rsp_if.last_of_run,
                     rsp_if.status.name(), rsp_if.entries_held);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d of %0d requests sent and %0d results outstanding.",
               requests_sent, total_requests, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : run_test
    int directed_count;
    bit first_episode;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_APPEND;
    req_if.operand_value = '0;
    rsp_if.ready = 1'b0;

    // Empty list corner cases, then extremes, middle, head and tail deletes,
    // duplicates, and emptying the list by deletes.
    add_request(ACT_DUMP, 32'sh1234_5678);
    add_request(ACT_DELETE, 5);
    add_request(ACT_CLEAR, -1);
    add_request(ACT_APPEND, 32'sh8000_0000);
    add_request(ACT_APPEND, 32'sh7FFF_FFFF);
    add_request(ACT_APPEND, -1);
    add_request(ACT_APPEND, 0);
    add_request(ACT_APPEND, 1);
    add_request(ACT_DUMP, 0);
    add_request(ACT_DELETE, -1);
    add_request(ACT_DELETE, 5);
    add_request(ACT_DELETE, 32'sh8000_0000);
    add_request(ACT_DELETE, 1);
    add_request(ACT_APPEND, 7);
    add_request(ACT_APPEND, 7);
    add_request(ACT_APPEND, -7);
    add_request(ACT_DELETE, 7);
    add_request(ACT_DUMP, 32'sh7FFF_FFFF);
    add_request(ACT_DELETE, 32'sh7FFF_FFFF);
    add_request(ACT_DELETE, 0);
    add_request(ACT_DELETE, 7);
    add_request(ACT_DELETE, -7);
    add_request(ACT_DUMP, 32'sh8000_0000);
    add_request(ACT_APPEND, 32'sh5555_AAAA);
    add_request(ACT_CLEAR, 0);
    directed_count = pending_requests.size();

    // The first episode always fills the list so the full case is reached.
    first_episode = 1'b1;
    while (pending_requests.size() < directed_count + RANDOM_REQUESTS) begin
      if (first_episode || $urandom_range(0, 5) == 0) add_fill_episode();
      else add_mixed_episode();
      first_episode = 1'b0;
    end
    total_requests = pending_requests.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_sent < total_requests) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d appends, %0d deletes, %0d dumps, %0d clears; %0d results.",
             requests_sent, action_counts[ACT_APPEND], action_counts[ACT_DELETE],
             action_counts[ACT_DUMP], action_counts[ACT_CLEAR], results_seen);
    $display("Full refusals %0d, unmatched deletes %0d, empty dumps %0d, longest list %0d.",
             full_refusals, missed_deletes, empty_dumps, longest_list);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
